/* hw/rtl/hldf_pkg.sv */
// Shared types, character codes and job kinds of the hex line dump formatter.
package hldf_pkg;

  localparam int LINE_BYTES      = 16;
  localparam int LINE_WORDS      = 8;
  localparam int OFFSET_MAX_BITS = 64;
  localparam int MIN_DIGITS      = 7;

  localparam logic [6:0] CHAR_SP   = 7'h20;
  localparam logic [6:0] CHAR_NL   = 7'h0A;
  localparam logic [6:0] CHAR_STAR = 7'h2A;

  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_STAR  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
    logic       end_of_write;
  } in_t;

  typedef struct packed {
    logic [6:0] text_char;
    logic       last_char;
  } out_t;

  // One print job from the front to the emitter.
  typedef struct packed {
    logic [1:0]                   kind;
    logic [OFFSET_MAX_BITS-1:0]   offset;
    logic [3:0]                   nwords;
    logic [LINE_BYTES*8-1:0]      words;
  } job_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    case (nib)
      4'h0: c = 7'h30;
      4'h1: c = 7'h31;
      4'h2: c = 7'h32;
      4'h3: c = 7'h33;
      4'h4: c = 7'h34;
      4'h5: c = 7'h35;
      4'h6: c = 7'h36;
      4'h7: c = 7'h37;
      4'h8: c = 7'h38;
      4'h9: c = 7'h39;
      4'ha: c = 7'h61;
      4'hb: c = 7'h62;
      4'hc: c = 7'h63;
      4'hd: c = 7'h64;
      4'he: c = 7'h65;
      default: c = 7'h66;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/hldf_front.sv */
// Front end: gathers bytes into lines, detects repeats and issues print jobs.
module hldf_front #(
  parameter int OFFSET_BITS = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  hldf_pkg::in_t in_data,
  input  logic          q_full,
  output logic          push,
  output hldf_pkg::job_t job
);
  import hldf_pkg::*;

  logic [7:0]              line_bytes [LINE_BYTES];
  logic [4:0]              line_fill;
  logic [OFFSET_BITS-1:0]  byte_total;
  logic [LINE_BYTES*8-1:0] prev_words;
  logic                    repeat_marked;
  logic                    no_line_yet;

  logic                    accept;
  logic                    is_close;
  logic [4:0]              fill_next;
  logic [4:0]              fill_plus;
  logic [LINE_BYTES*8-1:0] words_cur;
  logic [OFFSET_BITS-1:0]  total_next;
  logic [OFFSET_BITS-1:0]  line_start;
  logic                    line_done;
  logic                    is_repeat;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_close = in_data.req_type;

  assign fill_next  = line_fill + 5'd1;
  assign fill_plus  = fill_next + 5'd1;
  assign total_next = byte_total + OFFSET_BITS'(1);
  assign line_start = total_next - OFFSET_BITS'(fill_next);
  assign line_done  = (fill_next == 5'(LINE_BYTES)) || in_data.end_of_write;

  // The line as it stands with the incoming byte; bytes past the fill read as zero.
  always_comb begin
    for (int j = 0; j < LINE_BYTES; j++) begin
      if (5'(j) >= fill_next) begin
        words_cur[8*j +: 8] = 8'h00;
      end else if (4'(j) == line_fill[3:0]) begin
        words_cur[8*j +: 8] = in_data.data_byte;
      end else begin
        words_cur[8*j +: 8] = line_bytes[j];
      end
    end
  end

  assign is_repeat = !no_line_yet && (words_cur == prev_words);

  always_comb begin
    push       = 1'b0;
    job.kind   = KIND_LINE;
    job.offset = OFFSET_MAX_BITS'(line_start);
    job.nwords = fill_plus[4:1];
    job.words  = words_cur;
    if (accept) begin
      if (is_close) begin
        push       = 1'b1;
        job.kind   = KIND_CLOSE;
        job.offset = OFFSET_MAX_BITS'(byte_total);
      end else if (line_done) begin
        if (!is_repeat) begin
          push = 1'b1;
        end else if (!repeat_marked) begin
          push     = 1'b1;
          job.kind = KIND_STAR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_close) begin
      line_bytes[line_fill[3:0]] <= in_data.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_fill     <= '0;
      byte_total    <= '0;
      prev_words    <= '0;
      repeat_marked <= 1'b0;
      no_line_yet   <= 1'b1;
    end else if (accept) begin
      if (is_close) begin
        line_fill     <= '0;
        byte_total    <= '0;
        prev_words    <= '0;
        repeat_marked <= 1'b0;
        no_line_yet   <= 1'b1;
      end else begin
        byte_total <= total_next;
        if (line_done) begin
          line_fill   <= '0;
          no_line_yet <= 1'b0;
          if (is_repeat) begin
            repeat_marked <= 1'b1;
          end else begin
            prev_words    <= words_cur;
            repeat_marked <= 1'b0;
          end
        end else begin
          line_fill <= fill_next;
        end
      end
    end
  end

endmodule

/* hw/rtl/hldf_queue.sv */
// Two-entry job queue between the front end and the character emitter.
module hldf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hldf_pkg::job_t push_job,
  input  logic           pop,
  output hldf_pkg::job_t head,
  output logic           full,
  output logic           empty
);
  import hldf_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head  = entries[rd_ptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/hldf_back.sv */
// Back end: expands print jobs into dump text, one character per cycle while out_stall is low.
module hldf_back #(
  parameter int OFFSET_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  hldf_pkg::job_t head,
  input  logic           q_empty,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output hldf_pkg::out_t out_data
);
  import hldf_pkg::*;

  localparam int DIGITS = (OFFSET_BITS + 3) / 4;
  localparam int OW     = DIGITS * 4;
  localparam int CW     = $clog2(DIGITS + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DIGITS);
  localparam logic [CW-1:0] CNT_MIN  = CW'(MIN_DIGITS);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFF  = 3'd1;
  localparam logic [2:0] ST_SP   = 3'd2;
  localparam logic [2:0] ST_BODY = 3'd3;
  localparam logic [2:0] ST_STAR = 3'd4;
  localparam logic [2:0] ST_NL   = 3'd5;

  logic [2:0]              state, state_next;
  logic [1:0]              kind, kind_next;
  logic [OW-1:0]           off_sh, off_sh_next;
  logic [CW-1:0]           dig_cnt, dig_cnt_next;
  logic                    lead, lead_next;
  logic [3:0]              nwords, nwords_next;
  logic [LINE_BYTES*8-1:0] words, words_next;
  logic [2:0]              wi, wi_next;
  logic [2:0]              wk, wk_next;

  logic       adv;
  logic       emit;
  logic [6:0] ch;
  logic       last;
  logic [3:0] nib;
  logic [15:0] cur_word;
  logic [3:0] word_nib;

  assign adv      = !out_valid || !out_stall;
  assign nib      = off_sh[OW-1 -: 4];
  assign cur_word = words[16*wi +: 16];

  always_comb begin
    case (wk[1:0])
      2'd0:    word_nib = cur_word[15:12];
      2'd1:    word_nib = cur_word[11:8];
      2'd2:    word_nib = cur_word[7:4];
      default: word_nib = cur_word[3:0];
    endcase
  end

  always_comb begin
    state_next   = state;
    kind_next    = kind;
    off_sh_next  = off_sh;
    dig_cnt_next = dig_cnt;
    lead_next    = lead;
    nwords_next  = nwords;
    words_next   = words;
    wi_next      = wi;
    wk_next      = wk;
    pop          = 1'b0;
    emit         = 1'b0;
    ch           = CHAR_SP;
    last         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          kind_next    = head.kind;
          off_sh_next  = head.offset[OW-1:0];
          dig_cnt_next = CNT_FULL;
          lead_next    = 1'b1;
          nwords_next  = head.nwords;
          words_next   = head.words;
          state_next   = (head.kind == KIND_STAR) ? ST_STAR : ST_OFF;
        end
      end
      ST_OFF: begin
        if (adv) begin
          // Leading zero digits above the minimum width are dropped.
          if (lead && (nib == 4'h0) && (dig_cnt > CNT_MIN)) begin
            emit = 1'b0;
          end else begin
            emit      = 1'b1;
            lead_next = 1'b0;
          end
          ch           = hex_char(nib);
          off_sh_next  = off_sh << 4;
          dig_cnt_next = dig_cnt - CNT_ONE;
          if (dig_cnt == CNT_ONE) begin
            state_next = (kind == KIND_CLOSE) ? ST_NL : ST_SP;
          end
        end
      end
      ST_SP: begin
        if (adv) begin
          emit       = 1'b1;
          wi_next    = 3'd0;
          wk_next    = 3'd0;
          state_next = ST_BODY;
        end
      end
      ST_BODY: begin
        if (adv) begin
          emit = 1'b1;
          if (({1'b0, wi} < nwords) && (wk != 3'd4)) begin
            ch = hex_char(word_nib);
          end
          if ((wi == 3'd7) && (wk == 3'd3)) begin
            state_next = ST_NL;
          end else if (wk == 3'd4) begin
            wk_next = 3'd0;
            wi_next = wi + 3'd1;
          end else begin
            wk_next = wk + 3'd1;
          end
        end
      end
      ST_STAR: begin
        if (adv) begin
          emit       = 1'b1;
          ch         = CHAR_STAR;
          state_next = ST_NL;
        end
      end
      ST_NL: begin
        if (adv) begin
          emit       = 1'b1;
          ch         = CHAR_NL;
          last       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    kind    <= kind_next;
    off_sh  <= off_sh_next;
    dig_cnt <= dig_cnt_next;
    lead    <= lead_next;
    nwords  <= nwords_next;
    words   <= words_next;
    wi      <= wi_next;
    wk      <= wk_next;
    if (adv) begin
      out_data.text_char <= ch;
      out_data.last_char <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        out_valid <= emit;
      end
    end
  end

endmodule

/* hw/rtl/hex_line_dump_formatter.sv */
// Top level of the hex line dump formatter: front end, job queue and emitter.
// Bytes are taken one per cycle while in_stall is low and gathered into 16-byte
// lines; each completed new line becomes a print job in a two-entry queue, a first
// repeat becomes a star job and further repeats none, so the input keeps flowing
// while text goes out. The emitter sends one character per cycle while out_stall
// is low, loads each job in its idle state and drops every leading zero offset
// digit above seven (at the default 32-bit offset, only the top digit). A star
// job prints a star and a newline, and a suppressed repeat prints nothing.
module hex_line_dump_formatter #(
  parameter int OFFSET_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  hldf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output hldf_pkg::out_t out_data
);
  import hldf_pkg::*;

  job_t push_job;
  job_t head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  hldf_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .push    (q_push),
    .job     (push_job)
  );

  hldf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_job(push_job),
    .pop     (q_pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  hldf_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_empty  (q_empty),
    .pop      (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The last_char flag is set on every newline character, and only there.
  a_last_is_newline: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.text_char == CHAR_NL) == out_data.last_char))
    else $error("last_char does not match the newline");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

endmodule
